/* hw/rtl/bda_pkg.sv */
// Shared types, codes and reset values for the button debounce and auto-repeat block.
package bda_pkg;

	localparam int CountW = 8;
	localparam int ModeW  = 2;
	localparam int CodeW  = 2;
	localparam int PinW   = 2;
	localparam int CfgIdxW = 2;

	localparam logic [ModeW-1:0] MODE_IDLE   = 2'd0;
	localparam logic [ModeW-1:0] MODE_SETTLE = 2'd1;
	localparam logic [ModeW-1:0] MODE_HELD   = 2'd2;

	localparam logic [CodeW-1:0] CODE_NONE  = 2'd0;
	localparam logic [CodeW-1:0] CODE_LEFT  = 2'd1;
	localparam logic [CodeW-1:0] CODE_RIGHT = 2'd2;

	localparam logic [PinW-1:0] PINS_LEFT  = 2'b10;
	localparam logic [PinW-1:0] PINS_RIGHT = 2'b01;

	localparam logic [CfgIdxW-1:0] REG_SETTLE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_RELEASE = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_REPEAT  = 2'd2;

	localparam logic [CountW-1:0] SETTLE_RESET  = 8'd1;
	localparam logic [CountW-1:0] RELEASE_RESET = 8'd1;
	localparam logic [CountW-1:0] REPEAT_RESET  = 8'd20;

	typedef struct packed {
		logic [CountW-1:0] settle_ticks;
		logic [CountW-1:0] release_ticks;
		logic [CountW-1:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic [CodeW-1:0] button_code;
		logic             rearm;
	} res_t;

endpackage

/* hw/rtl/bda_cfg_regs.sv */
// Configuration register file for settle, release and repeat periods.
module bda_cfg_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [bda_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [bda_pkg::CountW-1:0]  cfg_wdata,
	output bda_pkg::cfg_t          cfg
);
	import bda_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks  <= SETTLE_RESET;
			cfg_q.release_ticks <= RELEASE_RESET;
			cfg_q.repeat_ticks  <= REPEAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE:  cfg_q.settle_ticks  <= cfg_wdata;
				REG_RELEASE: cfg_q.release_ticks <= cfg_wdata;
				REG_REPEAT:  cfg_q.repeat_ticks  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/bda_fsm.sv */
// Debounce state machine: idle, settle and held modes with release and repeat counters.
module bda_fsm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      kind,
	input  logic                      notice_active,
	input  logic [bda_pkg::PinW-1:0]  buttons,
	input  bda_pkg::cfg_t             cfg,
	output logic                      res_valid,
	output bda_pkg::res_t             res
);
	import bda_pkg::*;

	logic [ModeW-1:0]  mode_q, mode_d;
	logic              pending_q, pending_d;
	logic [CountW-1:0] settle_q, settle_d;
	logic [CountW-1:0] release_q, release_d;
	logic [CountW-1:0] repeat_q, repeat_d;
	logic              left, right;

	assign left  = (buttons == PINS_LEFT);
	assign right = (buttons == PINS_RIGHT);

	always_comb begin
		mode_d          = mode_q;
		pending_d       = pending_q;
		settle_d        = settle_q;
		release_d       = release_q;
		repeat_d        = repeat_q;
		res.button_code = CODE_NONE;
		res.rearm       = 1'b0;
		res_valid       = accept && !kind;
		if (accept && kind) begin
			pending_d = notice_active;
		end else if (accept) begin
			unique case (mode_q)
				MODE_SETTLE: begin
					if (settle_q == '0) begin
						if (left || right) begin
							res.button_code = left ? CODE_LEFT : CODE_RIGHT;
							release_d       = cfg.release_ticks;
							repeat_d        = cfg.repeat_ticks;
							mode_d          = MODE_HELD;
						end else begin
							mode_d    = MODE_IDLE;
							pending_d = 1'b0;
							res.rearm = 1'b1;
						end
					end else begin
						settle_d = settle_q - 1'b1;
					end
				end
				MODE_HELD: begin
					if (release_q == '0) begin
						mode_d    = MODE_IDLE;
						pending_d = 1'b0;
						res.rearm = 1'b1;
					end else if (!left && !right) begin
						release_d = release_q - 1'b1;
					end else begin
						release_d = cfg.release_ticks;
						if (repeat_q == '0) begin
							if (left) begin
								res.button_code = CODE_LEFT;
							end
							repeat_d = cfg.repeat_ticks;
						end else if (left) begin
							repeat_d = repeat_q - 1'b1;
						end
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					if (pending_q) begin
						settle_d = cfg.settle_ticks;
						mode_d   = MODE_SETTLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			pending_q <= 1'b0;
			settle_q  <= '0;
			release_q <= '0;
			repeat_q  <= '0;
		end else begin
			mode_q    <= mode_d;
			pending_q <= pending_d;
			settle_q  <= settle_d;
			release_q <= release_d;
			repeat_q  <= repeat_d;
		end
	end

endmodule

/* hw/rtl/bda_out_buf.sv */
// Result register with a skid entry so the input side can deliver one more result while output stalls.
module bda_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bda_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_ready,
	output bda_pkg::res_t out_data
);
	import bda_pkg::*;

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

/* hw/rtl/button_debounce_autorepeat_core.sv */
// Top level of the two-button debouncer with left-button auto-repeat.
//
// Input channel (in_valid/in_ready): one item per transfer. kind 0 is a
// periodic tick carrying the raw pins in buttons; kind 1 is a press notice
// whose notice_active loads the pending flag. A tick yields exactly one result
// (button_code, rearm); a notice yields none.
// Output channel (out_valid/out_ready): results in order of their ticks.
// Each result is registered in the result register or the skid entry.
// Throughput: one item per cycle while in_ready is high; the state update
// is a single pass of logic from the state registers to the result register.
// When the receiver stalls, a second result is held in a skid entry and
// in_ready drops only once both the result register and skid entry are full.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 settle,
// 1 release, 2 repeat) at once; index 3 is ignored. Write only while idle.
// Reset: arst_n clears both buffers, sets idle mode with the flag and all
// counters at zero, and loads the periods with 1, 1 and 20 ticks.
module button_debounce_autorepeat_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic                          notice_active,
	input  logic [bda_pkg::PinW-1:0]      buttons,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bda_pkg::CodeW-1:0]     button_code,
	output logic                          rearm,
	input  logic                          cfg_we,
	input  logic [bda_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bda_pkg::CountW-1:0]    cfg_wdata
);
	import bda_pkg::*;

	cfg_t cfg;
	res_t res, out_data;
	logic res_valid;
	logic full;
	logic accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	bda_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bda_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (kind),
		.notice_active (notice_active),
		.buttons       (buttons),
		.cfg           (cfg),
		.res_valid     (res_valid),
		.res           (res)
	);

	bda_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign button_code = out_data.button_code;
	assign rearm       = out_data.rearm;

endmodule

/* hw/rtl/bda_checker.sv */
// Port-level checks for the debouncer core and the bind that attaches them.
module bda_sva (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bda_pkg::CodeW-1:0]     button_code,
	input logic                          rearm
);
	import bda_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(button_code) && $stable(rearm))
		else $error("stalled result changed");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> button_code == CODE_NONE || button_code == CODE_LEFT
			|| button_code == CODE_RIGHT)
		else $error("illegal button code");

	a_code_rearm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rearm |-> button_code == CODE_NONE)
		else $error("code reported together with rearm");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && in_ready && !kind))
		else $error("result without an accepted tick");

endmodule

bind button_debounce_autorepeat_core bda_sva u_bda_sva (.*);
